### rtl/tfpr_pkg.sv
`timescale 1ns / 1ps
// Package for the two-finger pan recognizer: event and verdict codes,
// register indexes, reset values and the word types shared by all modules.
// No dependencies.
package tfpr_pkg;

    // Event kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_END    = 2'd2,
        FUNC_OTHER  = 2'd3
    } tfpr_func_t;

    // Verdicts carried on the output tuser
    typedef enum logic [1:0] {
        VERDICT_IGNORE  = 2'd0,
        VERDICT_TRIGGER = 2'd1,
        VERDICT_CANCEL  = 2'd2,
        VERDICT_FINISH  = 2'd3
    } tfpr_verdict_t;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_GESTURE_DELAY   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AXIS_TOLERANCE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CANCEL_DISTANCE = 2'd2;

    // Register reset values
    localparam logic [15:0] GESTURE_DELAY_RST   = 16'd150;
    localparam logic [15:0] AXIS_TOLERANCE_RST  = 16'd500;
    localparam logic [15:0] CANCEL_DISTANCE_RST = 16'd50;

    // A pan needs exactly this many touch points
    localparam logic [3:0] PAN_POINTS = 4'd2;

    // Stream word widths (fields padded to whole bytes)
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        tfpr_func_t         func;
        logic [31:0]        time_ms;
        logic [3:0]         point_count;
        logic               any_released;
        logic signed [15:0] first_move_x;
        logic signed [15:0] first_move_y;
        logic signed [15:0] second_move_x;
        logic signed [15:0] second_move_y;
        logic signed [15:0] step_x;
        logic signed [15:0] step_y;
    } tfpr_item_t;

    typedef struct packed {
        logic [15:0] gesture_delay;
        logic [15:0] axis_tolerance;
        logic [15:0] cancel_distance;
    } tfpr_cfg_t;

    typedef struct packed {
        logic [31:0]        begin_time;
        logic               pan_active;
        logic               delay_flag;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
    } tfpr_state_t;

endpackage

### rtl/tfpr_eval.sv
`timescale 1ns / 1ps
// Decision logic of the pan recognizer: one event plus the current gesture
// state in, verdict and next gesture state out. Uses tfpr_pkg.
module tfpr_eval import tfpr_pkg::*; (
    input  tfpr_item_t    item,
    input  tfpr_cfg_t     cfg,
    input  tfpr_state_t   state_cur,
    output tfpr_verdict_t verdict,
    output tfpr_state_t   state_next
);

    logic [31:0]        elapsed;
    logic               delay_pending;
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
    logic               x_pos;
    logic               y_pos;
    logic               x_agree;
    logic               y_agree;
    logic [16:0]        abs_ax;
    logic [16:0]        abs_ay;
    logic [16:0]        abs_bx;
    logic [16:0]        abs_by;
    logic [17:0]        dist_a;
    logic [17:0]        dist_b;
    logic               far_move;

    // Time since begin, modular
    assign elapsed       = item.time_ms - state_cur.begin_time;
    assign delay_pending = elapsed < {16'd0, cfg.gesture_delay};

    // Per-axis products of the two finger displacements
    assign prod_x = 32'(item.first_move_x) * 32'(item.second_move_x);
    assign prod_y = 32'(item.first_move_y) * 32'(item.second_move_y);
    assign mag_x  = 32'd0 - prod_x;
    assign mag_y  = 32'd0 - prod_y;
    assign x_pos  = !prod_x[31] && (prod_x != 32'sd0);
    assign y_pos  = !prod_y[31] && (prod_y != 32'sd0);

    // Near-axis correction: a small negative product counts as agreeing,
    // x first, then y against the corrected x
    assign x_agree = x_pos ||
                     (!x_pos && (mag_x <= {16'd0, cfg.axis_tolerance}) && y_pos);
    assign y_agree = y_pos ||
                     (!y_pos && (mag_y <= {16'd0, cfg.axis_tolerance}) && x_agree);

    // Manhattan length of each finger's displacement
    assign abs_ax = item.first_move_x[15]  ? 17'd0 - {1'b1, item.first_move_x}
                                           : {1'b0, item.first_move_x};
    assign abs_ay = item.first_move_y[15]  ? 17'd0 - {1'b1, item.first_move_y}
                                           : {1'b0, item.first_move_y};
    assign abs_bx = item.second_move_x[15] ? 17'd0 - {1'b1, item.second_move_x}
                                           : {1'b0, item.second_move_x};
    assign abs_by = item.second_move_y[15] ? 17'd0 - {1'b1, item.second_move_y}
                                           : {1'b0, item.second_move_y};
    assign dist_a = {1'b0, abs_ax} + {1'b0, abs_ay};
    assign dist_b = {1'b0, abs_bx} + {1'b0, abs_by};
    assign far_move = (dist_a > {2'd0, cfg.cancel_distance}) ||
                      (dist_b > {2'd0, cfg.cancel_distance});

    // Verdict and state update per event kind
    always_comb begin
        state_next = state_cur;
        verdict    = VERDICT_IGNORE;
        unique case (item.func)
            FUNC_BEGIN: begin
                state_next.begin_time = item.time_ms;
                state_next.pan_active = 1'b0;
                state_next.delay_flag = 1'b1;
                verdict               = VERDICT_TRIGGER;
            end
            FUNC_UPDATE: begin
                priority if (item.point_count > PAN_POINTS) begin
                    state_next.pan_active = 1'b0;
                    verdict               = VERDICT_CANCEL;
                end else if (item.point_count == PAN_POINTS) begin
                    priority if (item.any_released && state_cur.pan_active) begin
                        state_next.pan_active = 1'b0;
                        verdict               = VERDICT_FINISH;
                    end else if (delay_pending) begin
                        state_next.delta_x    = 16'sd0;
                        state_next.delta_y    = 16'sd0;
                        state_next.delay_flag = 1'b1;
                        state_next.pan_active = 1'b0;
                        verdict               = VERDICT_TRIGGER;
                    end else if (!(x_agree && y_agree) && far_move) begin
                        state_next.delay_flag = 1'b0;
                        state_next.pan_active = 1'b0;
                        verdict               = VERDICT_CANCEL;
                    end else begin
                        state_next.delay_flag = 1'b0;
                        state_next.delta_x    = item.step_x;
                        state_next.delta_y    = item.step_y;
                        state_next.pan_active = 1'b1;
                        verdict               = VERDICT_TRIGGER;
                    end
                end else begin
                    // fewer than two points: ignored, state kept
                    verdict = VERDICT_IGNORE;
                end
            end
            FUNC_END: begin
                if (state_cur.pan_active) begin
                    state_next.pan_active = 1'b0;
                    verdict               = VERDICT_FINISH;
                end
            end
            FUNC_OTHER: begin
            end
        endcase
    end

endmodule

### rtl/two_finger_pan_recognizer_core.sv
`timescale 1ns / 1ps
// Top level of the two-finger pan recognizer: stream ports, input and
// result registers, gesture state and configuration. Uses tfpr_pkg, tfpr_eval.
//
// Usage:
//   Touch events enter on the s_ stream, one word per event; the event kind
//   rides on s_tuser. Every event yields exactly one result word on the m_
//   stream: the verdict on m_tuser, the delay flag and held pan delta in
//   m_tdata. An event is registered at acceptance, evaluated against the
//   gesture state by one stage of logic (two 16x16 multiplies and compares)
//   and is written to the result register once that register is free,
//   which raises m_tvalid. While m_tready stays high a new event is taken
//   every cycle, so the sustained rate is one event per clock.
//   When m_tready is low the result register holds; the input register
//   still takes one more event, after which s_tready drops until the result
//   is taken.
//   The user must write registers through cfg_wr_en/cfg_addr/cfg_wdata only
//   while the block is idle; the block does not enforce this. Reset (aresetn
//   low, synchronous) empties both stages, clears the gesture state and loads
//   the defaults: gesture_delay 150, axis_tolerance 500, cancel_distance 50.
module two_finger_pan_recognizer_core import tfpr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata, low bit up: time_ms[31:0], point_count[35:32], any_released[36],
    // first_move_x, first_move_y, second_move_x, second_move_y, step_x,
    // step_y (16 bits each from bit 37), zero pad [135:133]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: func
    input  logic [1:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata, low bit up: delay_active[0], delta_x[16:1], delta_y[32:17],
    // zero pad [39:33]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // tuser: verdict
    output logic [1:0]            m_tuser,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    tfpr_item_t    in_item;
    tfpr_item_t    in_item_reg;
    logic          in_valid_reg;
    logic          advance;
    tfpr_cfg_t     cfg_reg;
    tfpr_state_t   state_reg;
    tfpr_state_t   state_next;
    tfpr_verdict_t ev_verdict;
    logic          out_valid_reg;
    tfpr_verdict_t out_verdict_reg;
    logic          out_delay_reg;
    logic [15:0]   out_dx_reg;
    logic [15:0]   out_dy_reg;

    // Unpack the input word
    always_comb begin
        in_item.func          = tfpr_func_t'(s_tuser);
        in_item.time_ms       = s_tdata[31:0];
        in_item.point_count   = s_tdata[35:32];
        in_item.any_released  = s_tdata[36];
        in_item.first_move_x  = s_tdata[52:37];
        in_item.first_move_y  = s_tdata[68:53];
        in_item.second_move_x = s_tdata[84:69];
        in_item.second_move_y = s_tdata[100:85];
        in_item.step_x        = s_tdata[116:101];
        in_item.step_y        = s_tdata[132:117];
    end

    // Handshake: the input stage moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Cleared at reset so the decision logic never sees an unknown event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_item_reg <= '0;
        end else if (s_tvalid && s_tready) begin
            in_item_reg <= in_item;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gesture_delay   <= GESTURE_DELAY_RST;
            cfg_reg.axis_tolerance  <= AXIS_TOLERANCE_RST;
            cfg_reg.cancel_distance <= CANCEL_DISTANCE_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_GESTURE_DELAY) begin
                cfg_reg.gesture_delay <= cfg_wdata;
            end
            if (cfg_addr == CFG_AXIS_TOLERANCE) begin
                cfg_reg.axis_tolerance <= cfg_wdata;
            end
            if (cfg_addr == CFG_CANCEL_DISTANCE) begin
                cfg_reg.cancel_distance <= cfg_wdata;
            end
        end
    end

    // Event evaluation
    tfpr_eval u_eval (
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .verdict    (ev_verdict),
        .state_next (state_next)
    );

    // Gesture state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_verdict_reg <= ev_verdict;
            out_delay_reg   <= state_next.delay_flag;
            out_dx_reg      <= state_next.delta_x;
            out_dy_reg      <= state_next.delta_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_verdict_reg;
    assign m_tdata  = {7'd0, out_dy_reg, out_dx_reg, out_delay_reg};

    // A finish or cancel always leaves the gesture inactive
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev_verdict == VERDICT_FINISH) |=> !state_reg.pan_active)
        else $error("finish left pan active");

    a_cancel_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ev_verdict == VERDICT_CANCEL) |=> !state_reg.pan_active)
        else $error("cancel left pan active");

    // Every evaluated event shows up as a result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("evaluated event produced no result");

    // An empty input stage always takes a word
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("empty input stage not ready");

endmodule
